@@ hdl/hsv2rgb_pkg.sv @@
package hsv2rgb_pkg;

    // load strobes for the two register stages held by one submodule
    typedef struct packed {
        logic load_a;
        logic load_b;
    } t_stage_en;

    // hue is offset by six full turns so the reduction works on unsigned values
    localparam logic [16:0] HUE_OFFSET = 17'd34560;
    localparam logic [16:0] HUE_SECTOR = 17'd960;

    // reciprocal of 15 for the coarse sector quotient, exact below 1052
    localparam logic [11:0] RECIP_15_COARSE = 12'd2185;
    localparam int          RECIP_15_COARSE_SHIFT = 15;
    // reciprocal of 6 for the sector index, exact below 128
    localparam logic [5:0]  RECIP_6 = 6'd43;
    localparam int          RECIP_6_SHIFT = 8;
    // floor(2^24 / 15), low by at most one after the shift
    localparam int          RECIP_15_FINE_SHIFT = 24;
    localparam logic [20:0] RECIP_15_FINE = 21'd1118481;

    localparam int OUT_W = 13;

    // sector codes, 60 degrees each
    localparam logic [2:0] SEC_RY = 3'd0;
    localparam logic [2:0] SEC_YG = 3'd1;
    localparam logic [2:0] SEC_GC = 3'd2;
    localparam logic [2:0] SEC_CB = 3'd3;
    localparam logic [2:0] SEC_BM = 3'd4;
    localparam logic [2:0] SEC_MR = 3'd5;

endpackage

@@ hdl/hsv2rgb_hue.sv @@
module hsv2rgb_hue
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  logic                 i_clk,
    input  t_stage_en            i_en,
    input  logic [15:0]          i_hue,
    input  logic [15:0]          i_saturation,
    input  logic [15:0]          i_brightness,
    output logic [9:0]           o_rem,
    output logic [2:0]           o_sector,
    output logic                 o_grey,
    output logic [FRAC_BITS:0]   o_sat,
    output logic [FRAC_BITS:0]   o_bri
);

    localparam int EW = FRAC_BITS + 17;
    localparam logic [EW-1:0] ONE_W = EW'(1) << FRAC_BITS;

    logic [16:0]        n_u, r_u;
    logic [22:0]        w_qprod;
    logic [6:0]         n_qd, r_qd;
    logic [FRAC_BITS:0] n_sat, n_bri, r_sat, r_bri;
    logic [EW-1:0]      w_sat_ext, w_bri_ext;
    logic [16:0]        w_rem_full;
    logic [12:0]        w_sprod;
    logic [4:0]         w_qs;
    logic [6:0]         w_sec_full;

    // stage a: unsigned hue, coarse quotient by 960, clamps
    always_comb begin
        n_u       = {i_hue[15], i_hue} + HUE_OFFSET;
        w_qprod   = 23'(n_u[16:6]) * 23'(RECIP_15_COARSE);
        n_qd      = w_qprod[RECIP_15_COARSE_SHIFT +: 7];
        w_sat_ext = {{(FRAC_BITS + 1){1'b0}}, i_saturation};
        w_bri_ext = {{(FRAC_BITS + 1){1'b0}}, i_brightness};
        if (i_saturation[15]) begin
            n_sat = '0;
        end else if (w_sat_ext > ONE_W) begin
            n_sat = ONE_W[FRAC_BITS:0];
        end else begin
            n_sat = w_sat_ext[FRAC_BITS:0];
        end
        if (i_brightness[15]) begin
            n_bri = '0;
        end else if (w_bri_ext > ONE_W) begin
            n_bri = ONE_W[FRAC_BITS:0];
        end else begin
            n_bri = w_bri_ext[FRAC_BITS:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_a) begin
            r_u   <= n_u;
            r_qd  <= n_qd;
            r_sat <= n_sat;
            r_bri <= n_bri;
        end
    end

    // stage b: remainder within the sector and sector index
    always_comb begin
        w_rem_full = r_u - 17'(r_qd) * HUE_SECTOR;
        w_sprod    = 13'(r_qd) * 13'(RECIP_6);
        w_qs       = w_sprod[RECIP_6_SHIFT +: 5];
        w_sec_full = r_qd - 7'(w_qs) * 7'd6;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_b) begin
            o_rem    <= w_rem_full[9:0];
            o_sector <= w_sec_full[2:0];
            o_grey   <= (r_sat == '0);
            o_sat    <= r_sat;
            o_bri    <= r_bri;
        end
    end

endmodule

@@ hdl/hsv2rgb_frac.sv @@
module hsv2rgb_frac
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  logic                 i_clk,
    input  t_stage_en            i_en,
    input  logic [9:0]           i_rem,
    input  logic [2:0]           i_sector,
    input  logic                 i_grey,
    input  logic [FRAC_BITS:0]   i_sat,
    input  logic [FRAC_BITS:0]   i_bri,
    output logic [FRAC_BITS-1:0] o_frac,
    output logic [FRAC_BITS:0]   o_p,
    output logic [2:0]           o_sector,
    output logic                 o_grey,
    output logic [FRAC_BITS:0]   o_sat,
    output logic [FRAC_BITS:0]   o_bri
);

    localparam int YW = FRAC_BITS + 4;
    localparam int PW = YW + 21;
    localparam int MW = 2 * FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic [YW-1:0]        w_y, r_y;
    logic [PW-1:0]        w_fprod;
    logic [FRAC_BITS-1:0] r_f0;
    logic [MW-1:0]        w_pprod;
    logic [FRAC_BITS:0]   r_p, r_sat, r_bri;
    logic [2:0]           r_sector;
    logic                 r_grey;
    logic [YW-1:0]        w_resid;

    // stage c: rem * 2^frac / 960 as (rem << (frac - 6)) / 15, and p
    always_comb begin
        w_y     = {i_rem, {(FRAC_BITS - 6){1'b0}}};
        w_fprod = PW'(w_y) * PW'(RECIP_15_FINE);
        w_pprod = MW'(i_bri) * MW'(ONE - i_sat);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_a) begin
            r_y      <= w_y;
            r_f0     <= w_fprod[RECIP_15_FINE_SHIFT +: FRAC_BITS];
            r_p      <= w_pprod[FRAC_BITS +: (FRAC_BITS + 1)];
            r_sector <= i_sector;
            r_grey   <= i_grey;
            r_sat    <= i_sat;
            r_bri    <= i_bri;
        end
    end

    // stage d: the reciprocal estimate is low by at most one
    assign w_resid = r_y - ((YW'(r_f0) << 4) - YW'(r_f0));

    always_ff @(posedge i_clk) begin
        if (i_en.load_b) begin
            o_frac   <= r_f0 + FRAC_BITS'(w_resid >= YW'(15));
            o_p      <= r_p;
            o_sector <= r_sector;
            o_grey   <= r_grey;
            o_sat    <= r_sat;
            o_bri    <= r_bri;
        end
    end

endmodule

@@ hdl/hsv2rgb_mix.sv @@
module hsv2rgb_mix
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  logic                 i_clk,
    input  t_stage_en            i_en,
    input  logic [FRAC_BITS-1:0] i_frac,
    input  logic [FRAC_BITS:0]   i_p,
    input  logic [2:0]           i_sector,
    input  logic                 i_grey,
    input  logic [FRAC_BITS:0]   i_sat,
    input  logic [FRAC_BITS:0]   i_bri,
    output logic [FRAC_BITS:0]   o_q,
    output logic [FRAC_BITS:0]   o_t,
    output logic [FRAC_BITS:0]   o_p,
    output logic [FRAC_BITS:0]   o_bri,
    output logic [2:0]           o_sector,
    output logic                 o_grey
);

    localparam int MW = 2 * FRAC_BITS + 2;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic [MW-1:0]      w_sf_prod, w_sg_prod, w_q_prod, w_t_prod;
    logic [FRAC_BITS:0] r_sf, r_sg, r_p, r_bri;
    logic [2:0]         r_sector;
    logic               r_grey;

    // stage e: s*f and s*(1-f)
    always_comb begin
        w_sf_prod = MW'(i_sat) * MW'(i_frac);
        w_sg_prod = MW'(i_sat) * MW'(ONE - (FRAC_BITS + 1)'(i_frac));
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_a) begin
            r_sf     <= w_sf_prod[FRAC_BITS +: (FRAC_BITS + 1)];
            r_sg     <= w_sg_prod[FRAC_BITS +: (FRAC_BITS + 1)];
            r_p      <= i_p;
            r_bri    <= i_bri;
            r_sector <= i_sector;
            r_grey   <= i_grey;
        end
    end

    // stage f: q and t, both scaled by v
    always_comb begin
        w_q_prod = MW'(r_bri) * MW'(ONE - r_sf);
        w_t_prod = MW'(r_bri) * MW'(ONE - r_sg);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.load_b) begin
            o_q      <= w_q_prod[FRAC_BITS +: (FRAC_BITS + 1)];
            o_t      <= w_t_prod[FRAC_BITS +: (FRAC_BITS + 1)];
            o_p      <= r_p;
            o_bri    <= r_bri;
            o_sector <= r_sector;
            o_grey   <= r_grey;
        end
    end

endmodule

@@ hdl/hsv_to_rgb_converter_top.sv @@
// hsv to rgb converter: one hsv colour per transaction in, one rgb colour per
// transaction out, no state between colours. hue is a signed angle in 1/16
// degree and wraps modulo 360 degrees; saturation and brightness are clamped
// to 0..1.0 (FRAC_BITS fraction bits). outputs are truncated and kept to
// 13 bits. the datapath is a seven stage pipeline: hue reduction (2 stages),
// fraction and p (2 stages), the s*f / v*(1-x) multiplier pairs (2 stages)
// and the sector select into the output register. one colour is accepted
// every clock while the output is not stalled. every stage has its own valid
// bit and loads when it is empty or the stage after it moves, so bubbles
// close up and a stalled output only holds the stages that are actually full
// behind it.
module hsv_to_rgb_converter_top
    import hsv2rgb_pkg::*;
#(
    parameter int FRAC_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] hue, [31:16] saturation, [47:32] brightness
    input  logic [47:0] i_s_axis_tdata,
    // master side
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [12:0] red, [25:13] green, [38:26] blue, [39] zero
    output logic [39:0] o_m_axis_tdata
);

    localparam int NS = 7;
    localparam int VW = FRAC_BITS + 1;
    localparam logic [VW-1:0] ONE = VW'(1) << FRAC_BITS;

    // pipeline control
    logic [NS-1:0] r_vld, n_vld, w_rdy;

    always_comb begin
        w_rdy[NS-1] = ~r_vld[NS-1] | i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_rdy[k] = ~r_vld[k] | w_rdy[k+1];
        end
        n_vld = r_vld;
        if (w_rdy[0]) begin
            n_vld[0] = i_s_axis_tvalid;
        end
        for (int k = 1; k < NS; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_vld[NS-1];

    t_stage_en w_en_hue, w_en_frac, w_en_mix;

    assign w_en_hue  = '{load_a: w_rdy[0], load_b: w_rdy[1]};
    assign w_en_frac = '{load_a: w_rdy[2], load_b: w_rdy[3]};
    assign w_en_mix  = '{load_a: w_rdy[4], load_b: w_rdy[5]};

    // hue reduction and clamps
    logic [9:0]    w_rem;
    logic [2:0]    w_sec_h, w_sec_f, w_sec_m;
    logic          w_grey_h, w_grey_f, w_grey_m;
    logic [VW-1:0] w_sat_h, w_bri_h, w_sat_f, w_bri_f, w_bri_m;
    logic [FRAC_BITS-1:0] w_frac;
    logic [VW-1:0] w_p_f, w_p_m, w_q, w_t;

    hsv2rgb_hue #(.FRAC_BITS(FRAC_BITS)) u_hue (
        .i_clk        (i_clk),
        .i_en         (w_en_hue),
        .i_hue        (i_s_axis_tdata[15:0]),
        .i_saturation (i_s_axis_tdata[31:16]),
        .i_brightness (i_s_axis_tdata[47:32]),
        .o_rem        (w_rem),
        .o_sector     (w_sec_h),
        .o_grey       (w_grey_h),
        .o_sat        (w_sat_h),
        .o_bri        (w_bri_h)
    );

    // fractional position in the sector, and p
    hsv2rgb_frac #(.FRAC_BITS(FRAC_BITS)) u_frac (
        .i_clk    (i_clk),
        .i_en     (w_en_frac),
        .i_rem    (w_rem),
        .i_sector (w_sec_h),
        .i_grey   (w_grey_h),
        .i_sat    (w_sat_h),
        .i_bri    (w_bri_h),
        .o_frac   (w_frac),
        .o_p      (w_p_f),
        .o_sector (w_sec_f),
        .o_grey   (w_grey_f),
        .o_sat    (w_sat_f),
        .o_bri    (w_bri_f)
    );

    // q and t
    hsv2rgb_mix #(.FRAC_BITS(FRAC_BITS)) u_mix (
        .i_clk    (i_clk),
        .i_en     (w_en_mix),
        .i_frac   (w_frac),
        .i_p      (w_p_f),
        .i_sector (w_sec_f),
        .i_grey   (w_grey_f),
        .i_sat    (w_sat_f),
        .i_bri    (w_bri_f),
        .o_q      (w_q),
        .o_t      (w_t),
        .o_p      (w_p_m),
        .o_bri    (w_bri_m),
        .o_sector (w_sec_m),
        .o_grey   (w_grey_m)
    );

    // sector select into the output register
    logic [VW-1:0]      w_r, w_g, w_b;
    logic [VW+OUT_W-1:0] w_r_ext, w_g_ext, w_b_ext;
    logic [OUT_W-1:0]   r_red, r_green, r_blue;

    always_comb begin
        if (w_grey_m) begin
            w_r = w_bri_m;
            w_g = w_bri_m;
            w_b = w_bri_m;
        end else begin
            case (w_sec_m)
                SEC_RY: begin
                    w_r = w_bri_m; w_g = w_t;     w_b = w_p_m;
                end
                SEC_YG: begin
                    w_r = w_q;     w_g = w_bri_m; w_b = w_p_m;
                end
                SEC_GC: begin
                    w_r = w_p_m;   w_g = w_bri_m; w_b = w_t;
                end
                SEC_CB: begin
                    w_r = w_p_m;   w_g = w_q;     w_b = w_bri_m;
                end
                SEC_BM: begin
                    w_r = w_t;     w_g = w_p_m;   w_b = w_bri_m;
                end
                default: begin
                    w_r = w_bri_m; w_g = w_p_m;   w_b = w_q;
                end
            endcase
        end
        // zero-extend then keep the low output bits, for any fraction width
        w_r_ext = {{OUT_W{1'b0}}, w_r};
        w_g_ext = {{OUT_W{1'b0}}, w_g};
        w_b_ext = {{OUT_W{1'b0}}, w_b};
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NS-1]) begin
            r_red   <= w_r_ext[OUT_W-1:0];
            r_green <= w_g_ext[OUT_W-1:0];
            r_blue  <= w_b_ext[OUT_W-1:0];
        end
    end

    assign o_m_axis_tdata = {1'b0, r_blue, r_green, r_red};

`ifndef NO_ASSERTIONS
    // sector index reaching the sector select never exceeds five
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (w_sec_m <= SEC_MR))
        else $error("sector index out of range");

    // with a fraction width that fits, no channel exceeds 1.0
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (FRAC_BITS <= 12)) |->
        ((r_red <= OUT_W'(ONE)) && (r_green <= OUT_W'(ONE)) && (r_blue <= OUT_W'(ONE))))
        else $error("colour channel above full scale");

    // a full pipeline behind a stalled output takes no new colour
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input accepted while pipeline is full and stalled");

    // a colour accepted into an empty pipeline sits in the first stage next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && (r_vld == '0) && i_m_axis_tready)
        |-> ##1 r_vld[0])
        else $error("accepted colour not captured in first stage");
`endif

endmodule
